// ===== rtl/core/bsbi_pkg.sv =====
package bsbi_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int WORD_W = 32;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_INC  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INC_WB,
        ST_POP_RD,
        ST_POP_WB,
        ST_POP_OUT
    } state_t;

    typedef enum logic {
        REG_CAPACITY = 1'b0,
        REG_UNUSED   = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]               op;
        logic signed [WORD_W-1:0] value;
        logic [6:0]               count;
    } in_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] popped_value;
        logic                     was_empty;
    } out_item_t;

endpackage

// ===== rtl/core/bsbi_ram.sv =====
module bsbi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/bounded_stack_with_bottom_increment.sv =====
// Steps: push and ignored codes complete on acceptance; increment reads the pending add,
// then writes it back in ST_INC_WB; pop goes through ST_POP_RD, ST_POP_WB (skipped for the
// bottom entry) and ST_POP_OUT to the result register (empty pop goes straight to ST_POP_OUT),
// plus any wait for m_ready. Throughput: one item at a time; set by the read-modify-write of
// the pending-add memory, which has a single registered read port.
// Reset (aresetn low, synchronous): stack empty, capacity 64, no result pending;
// memory contents are not cleared and need no clearing pass.
module bounded_stack_with_bottom_increment (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  bsbi_pkg::in_item_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output bsbi_pkg::out_item_t          m_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int AW = bsbi_pkg::ADDR_W;
    localparam int CW = bsbi_pkg::CNT_W;
    localparam int WW = bsbi_pkg::WORD_W;

    bsbi_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic [CW-1:0]       cap_reg;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [WW-1:0]       val_reg, val_next;
    logic [WW-1:0]       res_reg, res_next;
    logic                empty_reg, empty_next;
    logic                m_valid_reg, m_valid_next;
    bsbi_pkg::out_item_t m_data_reg, m_data_next;

    logic                ent_we, ent_re, inc_we, inc_re;
    logic [AW-1:0]       ent_waddr, ent_raddr, inc_waddr, inc_raddr;
    logic [WW-1:0]       ent_wdata, inc_wdata, ent_rdata, inc_rdata;

    logic                accept;
    logic [CW-1:0]       eff_cap, k_clamp;
    logic                cfg_write;

    bsbi_ram #(.WIDTH(WW), .DEPTH(bsbi_pkg::DEPTH)) u_entry_ram (
        .aclk  (aclk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    bsbi_ram #(.WIDTH(WW), .DEPTH(bsbi_pkg::DEPTH)) u_pend_ram (
        .aclk  (aclk),
        .we    (inc_we),
        .waddr (inc_waddr),
        .wdata (inc_wdata),
        .re    (inc_re),
        .raddr (inc_raddr),
        .rdata (inc_rdata)
    );

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign prdata    = (bsbi_pkg::reg_idx_t'(paddr[2]) == bsbi_pkg::REG_CAPACITY)
                       ? {{(32-CW){1'b0}}, cap_reg} : 32'd0;

    assign s_ready = (state_reg == bsbi_pkg::ST_IDLE);
    assign accept  = s_valid & s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign eff_cap = (cap_reg > CW'(bsbi_pkg::DEPTH)) ? CW'(bsbi_pkg::DEPTH) : cap_reg;
    assign k_clamp = (s_data.count > fill_reg) ? fill_reg : s_data.count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bsbi_pkg::ST_IDLE;
            fill_reg    <= '0;
            cap_reg     <= bsbi_pkg::CAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
            if (cfg_write && bsbi_pkg::reg_idx_t'(paddr[2]) == bsbi_pkg::REG_CAPACITY) begin
                cap_reg <= pwdata[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        val_reg    <= val_next;
        res_reg    <= res_next;
        empty_reg  <= empty_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        idx_next     = idx_reg;
        val_next     = val_reg;
        res_next     = res_reg;
        empty_next   = empty_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ent_we       = 1'b0;
        ent_waddr    = fill_reg[AW-1:0];
        ent_wdata    = s_data.value;
        ent_re       = 1'b0;
        ent_raddr    = idx_reg;
        inc_we       = 1'b0;
        inc_waddr    = idx_reg;
        inc_wdata    = '0;
        inc_re       = 1'b0;
        inc_raddr    = idx_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            bsbi_pkg::ST_IDLE: begin
                if (accept) begin
                    val_next = s_data.value;
                    case (bsbi_pkg::op_t'(s_data.op))
                        bsbi_pkg::OP_PUSH: begin
                            if (fill_reg < eff_cap) begin
                                ent_we    = 1'b1;
                                inc_we    = 1'b1;
                                inc_waddr = fill_reg[AW-1:0];
                                inc_wdata = '0;
                                fill_next = fill_reg + CW'(1);
                            end
                        end
                        bsbi_pkg::OP_POP: begin
                            if (fill_reg == '0) begin
                                res_next   = '1;
                                empty_next = 1'b1;
                                state_next = bsbi_pkg::ST_POP_OUT;
                            end else begin
                                idx_next   = AW'(fill_reg - CW'(1));
                                ent_re     = 1'b1;
                                ent_raddr  = AW'(fill_reg - CW'(1));
                                inc_re     = 1'b1;
                                inc_raddr  = AW'(fill_reg - CW'(1));
                                fill_next  = fill_reg - CW'(1);
                                empty_next = 1'b0;
                                state_next = bsbi_pkg::ST_POP_RD;
                            end
                        end
                        bsbi_pkg::OP_INC: begin
                            if (k_clamp != '0) begin
                                idx_next   = AW'(k_clamp - CW'(1));
                                inc_re     = 1'b1;
                                inc_raddr  = AW'(k_clamp - CW'(1));
                                state_next = bsbi_pkg::ST_INC_WB;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            bsbi_pkg::ST_INC_WB: begin
                inc_we     = 1'b1;
                inc_wdata  = inc_rdata + val_reg;
                state_next = bsbi_pkg::ST_IDLE;
            end
            bsbi_pkg::ST_POP_RD: begin
                res_next = ent_rdata + inc_rdata;
                val_next = inc_rdata;
                if (idx_reg != '0) begin
                    idx_next   = idx_reg - AW'(1);
                    inc_re     = 1'b1;
                    inc_raddr  = idx_reg - AW'(1);
                    state_next = bsbi_pkg::ST_POP_WB;
                end else begin
                    state_next = bsbi_pkg::ST_POP_OUT;
                end
            end
            bsbi_pkg::ST_POP_WB: begin
                // push the pending add of the removed entry down one place
                inc_we     = 1'b1;
                inc_wdata  = inc_rdata + val_reg;
                state_next = bsbi_pkg::ST_POP_OUT;
            end
            bsbi_pkg::ST_POP_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.popped_value = res_reg;
                    m_data_next.was_empty    = empty_reg;
                    state_next               = bsbi_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bsbi_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
